// ===== src/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and controller/datapath interface types for the binary to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int INPUT_W    = 64;
  localparam int VALUE_BITS = 64;
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int DIG_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic push;
  } b2da_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic last_digit;
    logic out_free;
  } b2da_sts_t;

endpackage

// ===== src/b2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: load, shift-add-3 conversion, leading zero skip, digit emission.
// ----------------------------------------------------------------------------
module b2da_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b2da_pkg::b2da_sts_t sts_i,
  output b2da_pkg::b2da_cmd_t cmd_o
);
  import b2da_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.last_digit) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          if (sts_i.last_digit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/b2da_dp.sv =====
// ----------------------------------------------------------------------------
// b2da_dp
// Datapath: binary and BCD shift registers, counters and output word register.
// ----------------------------------------------------------------------------
module b2da_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [b2da_pkg::INPUT_W-1:0]  value_i,
  input  b2da_pkg::b2da_cmd_t           cmd_i,
  output b2da_pkg::b2da_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o
);
  import b2da_pkg::*;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIG_W-1:0]      dig_cnt_q, dig_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     digit_q, digit_d;
  logic                  last_q, last_d;
  logic [3:0]            top_nib;

  assign top_nib = bcd_q[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    dig_cnt_d   = dig_cnt_q;
    digit_d     = digit_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      bin_d     = value_i[VALUE_BITS-1:0];
      bcd_d     = '0;
      cnt_d     = CNT_W'(VALUE_BITS);
      dig_cnt_d = DIG_W'(NUM_DIGITS);
    end
    if (cmd_i.step) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.skip || cmd_i.push) begin
      bcd_d     = {bcd_q[BCD_W-5:0], 4'b0000};
      dig_cnt_d = dig_cnt_q - 1'b1;
    end
    if (cmd_i.push) begin
      digit_d     = ASCII_ZERO + {2'b00, top_nib};
      last_d      = (dig_cnt_q == DIG_W'(1));
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      dig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    digit_q <= digit_d;
    last_q  <= last_d;
  end

  assign sts_o.conv_done  = (cnt_q == CNT_W'(1));
  assign sts_o.top_zero   = (top_nib == 4'd0);
  assign sts_o.last_digit = (dig_cnt_q == DIG_W'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_q;
  assign last_o       = last_q;

  a_push_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> top_nib <= 4'd9)
    else $error("non-decimal digit emitted");

  a_skip_zero_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.skip |-> (top_nib == 4'd0) && (dig_cnt_q != DIG_W'(1)))
    else $error("skipped a significant digit");

  a_push_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> out_valid_q && (last_q == $past(dig_cnt_q == DIG_W'(1))))
    else $error("pushed word lost or mis-flagged");

endmodule

// ===== src/binary_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Binary to decimal ASCII converter: one input word, one output word per
// decimal digit, most significant first, leading zeros dropped.
// Sequence: the input is accepted, the 64-step shift-add-3 loop converts it, up
// to 19 leading zeros of the 20-digit value are skipped, and the digits are
// emitted one digit per cycle while the output is free (held by out_ready_i);
// the next input is taken only after the last digit.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [b2da_pkg::INPUT_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o
);
  import b2da_pkg::*;

  b2da_cmd_t cmd;
  b2da_sts_t sts;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2da_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

// ===== test/binary_to_decimal_ascii_checker.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_checker
// Watches both channels of the binary to decimal ASCII converter. Works out
// the decimal digits of every accepted number, queues them as expected digit
// words, and compares each delivered word with the oldest one waiting.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [b2da_pkg::INPUT_W-1:0] value_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [b2da_pkg::CHAR_W-1:0]  digit_char_i,
  input  logic                         last_i,
  output int                           mismatches_o,
  output int                           pending_o,
  output int                           numbers_o,
  output int                           digits_o
);
  import b2da_pkg::*;

  localparam int DIGIT_BASE  = 10;
  localparam int SHOWN_FAILS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_word_t;

  digit_word_t expected_digits[$];
  digit_word_t oldest;
  int          mismatches;
  int          numbers;
  int          digits;

  function automatic void queue_decimal_digits(input logic [INPUT_W-1:0] raw);
    logic [INPUT_W-1:0] rest;
    logic [3:0]         msd_first[$];
    digit_word_t        word;
    rest = raw & ~({INPUT_W{1'b1}} << VALUE_BITS);
    do begin
      msd_first.push_front(4'(rest % DIGIT_BASE));
      rest = rest / DIGIT_BASE;
    end while (rest != 0);
    foreach (msd_first[k]) begin
      word.digit_char = ASCII_ZERO + CHAR_W'(msd_first[k]);
      word.last       = (k == msd_first.size() - 1);
      expected_digits.push_back(word);
    end
  endfunction

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    numbers_o    = 0;
    digits_o     = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_digits.delete();
      mismatches = 0;
      numbers    = 0;
      digits     = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        queue_decimal_digits(value_i);
        numbers++;
      end
      if (out_valid_i && out_ready_i) begin
        digits++;
        if (expected_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_FAILS)
            $display("MISMATCH: unexpected digit word char=%0d last=%0b",
                     digit_char_i, last_i);
        end else begin
          oldest = expected_digits.pop_front();
          if (oldest.digit_char !== digit_char_i || oldest.last !== last_i) begin
            mismatches++;
            if (mismatches <= SHOWN_FAILS)
              $display("MISMATCH: digit word expected char=%0d last=%0b, got char=%0d last=%0b",
                       oldest.digit_char, oldest.last, digit_char_i, last_i);
          end
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_digits.size();
    numbers_o    <= numbers;
    digits_o     <= digits;
  end

endmodule

// ===== test/binary_to_decimal_ascii_top_test.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top_test
// Drives numbers into the binary to decimal ASCII converter: edge values of
// up to 20 digits first, then random numbers of spread magnitude under
// varying idle patterns and a long output hold-off. The checker beside the
// block predicts and compares every digit word.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top_test;
  import b2da_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [INPUT_W-1:0] value_i     = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_o;

  int mismatches;
  int pending;
  int numbers;
  int digits;
  int send_idle_pct = 20;
  int recv_idle_pct = 54;
  int hold_left     = 0;
  bit hold_req      = 1'b0;

  binary_to_decimal_ascii_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  binary_to_decimal_ascii_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_i (digit_char_o),
    .last_i       (last_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .numbers_o    (numbers),
    .digits_o     (digits)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   = hold_left - 1;
    end else if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_left   = HOLD_CYCLES - 1;
      hold_req    = 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input logic [INPUT_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int count, input int hold_at);
    logic [INPUT_W-1:0] v;
    logic [INPUT_W-1:0] pow10;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      if ($urandom_range(9) == 0) begin
        pow10 = 1;
        repeat ($urandom_range(19)) pow10 = pow10 * 10;
        v = pow10 + $urandom_range(2) - 1;
      end else begin
        v = {$urandom, $urandom} >> $urandom_range(63);
      end
      send_word(v);
    end
  endtask

  initial begin
    logic [INPUT_W-1:0] pow10;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(64'd0);
    send_word(64'd1);
    send_word(64'd9);
    send_word(64'd10);
    send_word(64'd99);
    send_word(64'd100);
    send_word(64'd1000000);
    send_word(64'd1234567890);
    send_word(64'h0000_0000_FFFF_FFFF);
    send_word(64'h0000_0001_0000_0000);
    send_word(64'd9999999999999999999);
    send_word(64'd10000000000000000000);
    send_word(64'd10000000000000000001);
    send_word(64'd12345678901234567890);
    send_word(64'h8000_0000_0000_0000);
    send_word(64'h8000_0000_0000_0001);
    send_word(64'hAAAA_AAAA_AAAA_AAAA);
    send_word(64'h5555_5555_5555_5555);
    send_word(64'hFFFF_FFFF_FFFF_FFFE);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    pow10 = 1;
    repeat (5) begin
      pow10 = pow10 * 1000;
      send_word(pow10 - 1);
    end
    wait_drained();

    send_random(85, 30);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 20;
    send_random(85, -1);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(90, -1);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Converted %0d numbers into %0d digit words, zero through 20-digit values,",
             numbers, digits);
    $display("under mixed idling and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("binary_to_decimal_ascii_top verification clean");
    end else begin
      $display("binary_to_decimal_ascii_top verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("binary_to_decimal_ascii_top verification failed");
    $finish;
  end

endmodule
